>>> design/lvpr_pkg.sv
// ----------------------------------------------------------------------------
// lvpr_pkg
// Shared constants and types for the longest balanced paren run block.
// ----------------------------------------------------------------------------
package lvpr_pkg;

    localparam int DEF_STACK_DEPTH = 1024;
    localparam int DEF_POS_WIDTH   = 16;

    localparam int SYM_W  = 8;
    localparam int BEST_W = 16;

    localparam logic [SYM_W-1:0]  OPEN_SYMBOL = 8'd40;
    localparam logic [BEST_W-1:0] BEST_MAX    = 16'hFFFF;

    // stack operation for one accepted transfer
    typedef struct packed {
        logic push;
        logic pop;
        logic clear;
    } t_stk_cmd;

endpackage

>>> design/longest_valid_paren_run.sv
// ----------------------------------------------------------------------------
// longest_valid_paren_run
// Longest balanced parenthesis run, one character a cycle while unstalled.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream s_axis: tdata carries one character byte, tlast marks the
//   final character of a string. Byte 40 opens; every other byte closes.
//   Output stream m_axis: one transfer per input transfer. tdata is the best
//   balanced run length so far in the string, tuser the sticky stack
//   overflow flag, tlast copies the input tlast.
//   The result is registered in the cycle after the input transfer.
//   Throughput: one character per cycle while the receiver takes results. The
//   stack top and the entry under it live in registers; the RAM entry below
//   those is read ahead, so a pop never waits on the RAM read port.
//   After the transfer with tlast, all string state clears at once.
//   Reset clears the stack count, position, run start, best length and
//   overflow flag; stack RAM contents are left as they are.
//   When the receiver stalls, the result is held in the output register and
//   s_axis tready drops until that result is taken.
// ----------------------------------------------------------------------------
module longest_valid_paren_run #(
    parameter int STACK_DEPTH = lvpr_pkg::DEF_STACK_DEPTH,
    parameter int POS_WIDTH   = lvpr_pkg::DEF_POS_WIDTH
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    input  logic [lvpr_pkg::SYM_W-1:0]  i_s_axis_tdata,   // [7:0] symbol
    input  logic                        i_s_axis_tlast,   // end_of_string
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    output logic [lvpr_pkg::BEST_W-1:0] o_m_axis_tdata,   // [15:0] best_length
    output logic                        o_m_axis_tuser,   // [0] overflow
    output logic                        o_m_axis_tlast    // final_result
);
    import lvpr_pkg::*;

    localparam int CW = $clog2(STACK_DEPTH) + 1;
    localparam int LW = POS_WIDTH + 1;
    localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

    t_stk_cmd             stk_cmd;
    logic [CW-1:0]        stk_count;
    logic                 stk_full;
    logic [POS_WIDTH-1:0] stk_sec;

    logic [POS_WIDTH-1:0] r_pos, n_pos;
    logic [POS_WIDTH-1:0] r_run, n_run;
    logic [BEST_W-1:0]    r_best, n_best;
    logic                 r_ovf, n_ovf;

    logic [BEST_W-1:0]    r_out_best;
    logic                 r_out_ovf;
    logic                 r_out_last;
    logic                 r_out_valid;

    logic                 acc;
    logic                 is_open;
    logic                 empty;
    logic [POS_WIDTH-1:0] pos_inc;
    logic [LW-1:0]        past;
    logic [LW-1:0]        run_ext;
    logic [LW-1:0]        len;
    logic [32:0]          len_ext;
    logic [BEST_W-1:0]    len_sat;
    logic [BEST_W-1:0]    best_now;
    logic                 ovf_now;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;

    assign is_open = (i_s_axis_tdata == OPEN_SYMBOL);
    assign empty   = (stk_count == '0);
    assign pos_inc = (r_pos == POS_MAX) ? r_pos : r_pos + POS_WIDTH'(1);

    assign stk_cmd.push  = acc && is_open;
    assign stk_cmd.pop   = acc && !is_open && !empty;
    assign stk_cmd.clear = acc && i_s_axis_tlast;

    lvpr_stack #(
        .STACK_DEPTH (STACK_DEPTH),
        .POS_WIDTH   (POS_WIDTH)
    ) u_stack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (stk_cmd),
        .i_push_data (r_pos),
        .o_count     (stk_count),
        .o_full      (stk_full),
        .o_sec       (stk_sec)
    );

    // run length on a pop: from run start if the stack empties, else from
    // the entry that becomes the new top; clamps to zero once positions saturate
    assign past    = {1'b0, r_pos} + LW'(1);
    assign run_ext = {1'b0, r_run};

    always_comb begin
        if (stk_count == CW'(1)) begin
            len = (run_ext > past) ? '0 : past - run_ext;
        end else begin
            len = (stk_sec > r_pos) ? '0 : {1'b0, r_pos - stk_sec};
        end
    end

    assign len_ext  = 33'(len);
    assign len_sat  = (len_ext > 33'(BEST_MAX)) ? BEST_MAX : len_ext[BEST_W-1:0];
    assign best_now = (stk_cmd.pop && (len_sat > r_best)) ? len_sat : r_best;
    assign ovf_now  = r_ovf || (stk_cmd.push && stk_full);

    always_comb begin
        n_pos  = r_pos;
        n_run  = r_run;
        n_best = r_best;
        n_ovf  = r_ovf;
        if (acc) begin
            if (i_s_axis_tlast) begin
                n_pos  = '0;
                n_run  = '0;
                n_best = '0;
                n_ovf  = 1'b0;
            end else begin
                n_pos  = pos_inc;
                n_best = best_now;
                n_ovf  = ovf_now;
                if (!is_open && empty) begin
                    n_run = pos_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_run       <= '0;
            r_best      <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pos  <= n_pos;
            r_run  <= n_run;
            r_best <= n_best;
            r_ovf  <= n_ovf;
            if (acc) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_out_best <= best_now;
            r_out_ovf  <= ovf_now;
            r_out_last <= i_s_axis_tlast;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_best;
    assign o_m_axis_tuser  = r_out_ovf;
    assign o_m_axis_tlast  = r_out_last;

endmodule

>>> design/lvpr_stack.sv
// ----------------------------------------------------------------------------
// lvpr_stack
// Position stack: entries in a synchronous RAM, top and second entry held in
// registers. The entry under the second one is read ahead every cycle so a pop
// can refill the second register without a stall.
// ----------------------------------------------------------------------------
module lvpr_stack #(
    parameter int STACK_DEPTH = lvpr_pkg::DEF_STACK_DEPTH,
    parameter int POS_WIDTH   = lvpr_pkg::DEF_POS_WIDTH
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lvpr_pkg::t_stk_cmd            i_cmd,
    input  logic [POS_WIDTH-1:0]          i_push_data,
    output logic [$clog2(STACK_DEPTH):0]  o_count,
    output logic                          o_full,
    output logic [POS_WIDTH-1:0]          o_sec
);
    import lvpr_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int CW = AW + 1;

    logic [POS_WIDTH-1:0] r_mem [STACK_DEPTH];
    logic [POS_WIDTH-1:0] r_rdata;
    logic [POS_WIDTH-1:0] r_top;
    logic [POS_WIDTH-1:0] r_sec;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        rd_ahead;
    logic                 push_ok;

    assign o_full  = (r_count == CW'(STACK_DEPTH));
    assign push_ok = i_cmd.push && !o_full;

    always_comb begin
        n_count = r_count;
        if (i_cmd.clear) begin
            n_count = '0;
        end else if (push_ok) begin
            n_count = r_count + CW'(1);
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
        end
    end

    // read the entry that sits under the second register after this cycle;
    // it never collides with the write address (old count)
    assign rd_ahead = n_count - CW'(3);

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_count[AW-1:0]] <= i_push_data;
        end
        r_rdata <= r_mem[rd_ahead[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_top <= i_push_data;
            r_sec <= r_top;
        end else if (i_cmd.pop) begin
            r_top <= r_sec;
            r_sec <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    assign o_count = r_count;
    assign o_sec   = r_sec;

endmodule
